@@ rtl/efp_pkg.sv @@
package efp_pkg;

  localparam int QW = 48;

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  localparam int OFFSET_W = 11;
  localparam int SCALE_W  = 32;
  localparam int LIMIT_W  = 8;
  localparam int SHADE_W  = 8;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_INV_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_INV_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_RE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_IM     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_LIMIT = 3'd7;

  // Register reset values
  localparam logic [OFFSET_W-1:0]  X_OFFSET_RST     = 11'd520;
  localparam logic [OFFSET_W-1:0]  Y_OFFSET_RST     = 11'd302;
  localparam logic [SCALE_W-1:0]   X_INV_SCALE_RST  = 32'd14810232;
  localparam logic [SCALE_W-1:0]   Y_INV_SCALE_RST  = 32'd21367997;
  localparam logic signed [QW-1:0] CONST_RE_RST     = -48'sd3014036250;
  localparam logic signed [QW-1:0] CONST_IM_RST     = -48'sd1650126435;
  localparam logic [LIMIT_W-1:0]   ESCAPE_LIMIT_RST = 8'd13;

  // Request to the shared multiplier
  typedef struct packed {
    logic go;
    logic frac;  // 1: Q16.32 product, drop 32 fraction bits; 0: integer product
  } mul_req_t;

  // Clamp an exact 49-bit sum to the signed 48-bit range
  function automatic logic signed [QW-1:0] sat48(input logic signed [QW:0] v);
    logic signed [QW-1:0] r;
    if (v[QW] != v[QW-1]) begin
      r = v[QW] ? Q_MIN : Q_MAX;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/escape_time_fractal_pixel_unit.sv @@
// Escape-time fractal shade unit (Mandelbrot or Julia).
// Command channel: raise start with pixel_x/pixel_y while busy is low; the
// pixel is taken at that edge and busy stays high until its shade is out.
// Result: shade is valid for exactly one cycle, marked by done. The receiver
// cannot stall; the result is simply presented and dropped after that cycle.
// Configuration: cfg_valid/cfg_ready write channel (cfg_ready is always high),
// cfg_index selects the register, cfg_data carries the value. Write only while
// busy is low.
// One shared 24x24 multiplier forms every product in four partial products;
// each z = z*z + c step runs three multiplies plus add, saturate and escape
// test. One pixel is in flight at a time.
// Reset returns the sequencer to idle, drops any pixel in flight and loads the
// default view: Mandelbrot mode, offsets 520/302, scales 1/290 and 1/201.
module escape_time_fractal_pixel_unit #(
  parameter int MAX_ITER   = 255,
  parameter int COORD_BITS = 11
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [COORD_BITS-1:0]                  pixel_x,
  input  logic [COORD_BITS-1:0]                  pixel_y,
  output logic                                   done,
  output logic [efp_pkg::SHADE_W-1:0]            shade,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [efp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [efp_pkg::QW-1:0]                 cfg_data
);
  import efp_pkg::*;

  localparam int ITW = $clog2(MAX_ITER + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MAPX, S_MAPY, S_MRR, S_MII, S_MRI, S_ADD1, S_ADD2, S_CHECK
  } state_t;

  state_t state;

  logic                     julia_mode;
  logic [OFFSET_W-1:0]      x_offset;
  logic [OFFSET_W-1:0]      y_offset;
  logic [SCALE_W-1:0]       x_inv_scale;
  logic [SCALE_W-1:0]       y_inv_scale;
  logic signed [QW-1:0]     const_re;
  logic signed [QW-1:0]     const_im;
  logic [LIMIT_W-1:0]       escape_limit;

  logic [COORD_BITS-1:0]    xoff_m;
  logic [COORD_BITS-1:0]    yoff_m;
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;

  logic signed [QW-1:0]     re;
  logic signed [QW-1:0]     im;
  logic signed [QW-1:0]     cre;
  logic signed [QW-1:0]     cim;
  logic signed [QW-1:0]     rr;
  logic signed [QW-1:0]     ii;
  logic signed [QW-1:0]     ri;
  logic signed [QW-1:0]     t_re;
  logic signed [QW-1:0]     t_im;
  logic [ITW-1:0]           n;
  logic                     issued;

  mul_req_t                 mreq;
  logic signed [QW-1:0]     mul_a;
  logic signed [QW-1:0]     mul_b;
  logic signed [QW-1:0]     mul_res;
  logic                     mul_done;

  logic signed [QW:0]       esc_sum;
  logic [QW:0]              esc_mag;
  logic                     escaped;
  logic [ITW-1:0]           left;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  // Offsets are taken modulo the coordinate width, like the pixel fields
  assign xoff_m = COORD_BITS'({{COORD_BITS{1'b0}}, x_offset});
  assign yoff_m = COORD_BITS'({{COORD_BITS{1'b0}}, y_offset});

  always_ff @(posedge clk) begin
    if (rst) begin
      julia_mode   <= 1'b0;
      x_offset     <= X_OFFSET_RST;
      y_offset     <= Y_OFFSET_RST;
      x_inv_scale  <= X_INV_SCALE_RST;
      y_inv_scale  <= Y_INV_SCALE_RST;
      const_re     <= CONST_RE_RST;
      const_im     <= CONST_IM_RST;
      escape_limit <= ESCAPE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_JULIA_MODE:   julia_mode   <= cfg_data[0];
        CFG_X_OFFSET:     x_offset     <= cfg_data[OFFSET_W-1:0];
        CFG_Y_OFFSET:     y_offset     <= cfg_data[OFFSET_W-1:0];
        CFG_X_INV_SCALE:  x_inv_scale  <= cfg_data[SCALE_W-1:0];
        CFG_Y_INV_SCALE:  y_inv_scale  <= cfg_data[SCALE_W-1:0];
        CFG_CONST_RE:     const_re     <= $signed(cfg_data);
        CFG_CONST_IM:     const_im     <= $signed(cfg_data);
        CFG_ESCAPE_LIMIT: escape_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier
  always_comb begin
    mreq.go   = 1'b0;
    mreq.frac = 1'b1;
    mul_a     = re;
    mul_b     = re;
    case (state)
      S_MAPX: begin
        mreq.go   = !issued;
        mreq.frac = 1'b0;
        mul_a     = {{(QW-1-COORD_BITS){dx[COORD_BITS]}}, dx};
        mul_b     = $signed({{(QW-SCALE_W){1'b0}}, x_inv_scale});
      end
      S_MAPY: begin
        mreq.go   = !issued;
        mreq.frac = 1'b0;
        mul_a     = {{(QW-1-COORD_BITS){dy[COORD_BITS]}}, dy};
        mul_b     = $signed({{(QW-SCALE_W){1'b0}}, y_inv_scale});
      end
      S_MRR: begin
        mreq.go = !issued;
      end
      S_MII: begin
        mreq.go = !issued;
        mul_a   = im;
        mul_b   = im;
      end
      S_MRI: begin
        mreq.go = !issued;
        mul_b   = im;
      end
      default: ;
    endcase
  end

  efp_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .req    (mreq),
    .a      (mul_a),
    .b      (mul_b),
    .result (mul_res),
    .done   (mul_done)
  );

  // Escape test on the exact, unsaturated sum
  always_comb begin
    esc_sum = {re[QW-1], re} + {im[QW-1], im};
    esc_mag = esc_sum[QW] ? ((QW+1)'(0) - esc_sum) : esc_sum;
    escaped = esc_mag[QW:32] > (QW-31)'(escape_limit);
    left    = ITW'(MAX_ITER) - n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      issued <= 1'b0;
      n      <= '0;
    end else begin
      done <= 1'b0;
      if (mreq.go) begin
        issued <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            dx     <= $signed({1'b0, pixel_x}) - $signed({1'b0, xoff_m});
            dy     <= $signed({1'b0, pixel_y}) - $signed({1'b0, yoff_m});
            issued <= 1'b0;
            state  <= S_MAPX;
          end
        end
        S_MAPX: begin
          if (mul_done) begin
            re     <= mul_res;
            issued <= 1'b0;
            state  <= S_MAPY;
          end
        end
        S_MAPY: begin
          if (mul_done) begin
            im     <= mul_res;
            cre    <= julia_mode ? const_re : re;
            cim    <= julia_mode ? const_im : mul_res;
            n      <= '0;
            issued <= 1'b0;
            state  <= S_MRR;
          end
        end
        S_MRR: begin
          if (mul_done) begin
            rr     <= mul_res;
            issued <= 1'b0;
            state  <= S_MII;
          end
        end
        S_MII: begin
          if (mul_done) begin
            ii     <= mul_res;
            issued <= 1'b0;
            state  <= S_MRI;
          end
        end
        S_MRI: begin
          if (mul_done) begin
            ri     <= mul_res;
            issued <= 1'b0;
            state  <= S_ADD1;
          end
        end
        S_ADD1: begin
          t_re  <= sat48({rr[QW-1], rr} - {ii[QW-1], ii});
          t_im  <= sat48({ri, 1'b0});
          state <= S_ADD2;
        end
        S_ADD2: begin
          re    <= sat48({t_re[QW-1], t_re} + {cre[QW-1], cre});
          im    <= sat48({t_im[QW-1], t_im} + {cim[QW-1], cim});
          state <= S_CHECK;
        end
        S_CHECK: begin
          // The escaping step is not counted
          if (escaped || (n + ITW'(1) == ITW'(MAX_ITER))) begin
            if (escaped) begin
              shade <= (left > ITW'(255)) ? 8'hFF : SHADE_W'(left);
            end else begin
              shade <= '0;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            n      <= n + ITW'(1);
            issued <= 1'b0;
            state  <= S_MRR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/efp_mul.sv @@
module efp_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  efp_pkg::mul_req_t               req,
  input  logic signed [efp_pkg::QW-1:0]   a,
  input  logic signed [efp_pkg::QW-1:0]   b,
  output logic signed [efp_pkg::QW-1:0]   result,
  output logic                            done
);
  import efp_pkg::*;

  localparam int HW = QW / 2;

  logic [QW-1:0]   ma;
  logic [QW-1:0]   mb;
  logic            neg;
  logic            frac;
  logic            active;
  logic [2:0]      cnt;
  logic [QW-1:0]   prod;
  logic [1:0]      psh;
  logic            pv;
  logic [2*QW-1:0] acc;
  logic [HW-1:0]   ha;
  logic [HW-1:0]   hb;
  logic [63:0]     p64;
  logic signed [QW-1:0] fin;
  logic [2*QW-1:0] addend;

  // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    ha = cnt[1] ? ma[QW-1:HW] : ma[HW-1:0];
    hb = cnt[0] ? mb[QW-1:HW] : mb[HW-1:0];
  end

  always_comb begin
    case (psh)
      2'd0:    addend = (2*QW)'(prod);
      2'd1:    addend = (2*QW)'(prod) << HW;
      2'd2:    addend = (2*QW)'(prod) << QW;
      default: addend = '0;
    endcase
  end

  always_comb begin
    p64 = frac ? acc[95:32] : acc[63:0];
    if (neg) begin
      if (p64 >= 64'h0000_8000_0000_0000) begin
        fin = Q_MIN;
      end else begin
        fin = -$signed(p64[QW-1:0]);
      end
    end else begin
      if (p64 > 64'h0000_7FFF_FFFF_FFFF) begin
        fin = Q_MAX;
      end else begin
        fin = $signed(p64[QW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      pv     <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.go && !active) begin
        ma     <= a[QW-1] ? (QW'(0) - a) : a;
        mb     <= b[QW-1] ? (QW'(0) - b) : b;
        neg    <= a[QW-1] ^ b[QW-1];
        frac   <= req.frac;
        acc    <= '0;
        cnt    <= '0;
        pv     <= 1'b0;
        active <= 1'b1;
      end else if (active) begin
        if (cnt < 3'd4) begin
          prod <= ha * hb;
          psh  <= 2'(cnt[0]) + 2'(cnt[1]);
          pv   <= 1'b1;
        end else begin
          pv   <= 1'b0;
        end
        if (pv) begin
          acc <= acc + addend;
        end
        if (cnt == 3'd5) begin
          result <= fin;
          done   <= 1'b1;
          active <= 1'b0;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

endmodule

@@ test/escape_time_fractal_pixel_unit_tb.sv @@
localparam int FRACTAL_STEPS = 255;
localparam int PIX_W = 11;

typedef struct packed {
  logic [PIX_W-1:0]            x;
  logic [PIX_W-1:0]            y;
  logic [efp_pkg::SHADE_W-1:0] shade;
} shade_exp_t;

typedef struct packed {
  logic                       julia;
  logic [PIX_W-1:0]           x_off;
  logic [PIX_W-1:0]           y_off;
  logic [efp_pkg::SCALE_W-1:0] x_scale;
  logic [efp_pkg::SCALE_W-1:0] y_scale;
  logic [efp_pkg::QW-1:0]     c_re;
  logic [efp_pkg::QW-1:0]     c_im;
  logic [efp_pkg::LIMIT_W-1:0] limit;
} view_t;

class shade_scoreboard;
  localparam longint Q_HI = efp_pkg::Q_MAX;
  localparam longint Q_LO = efp_pkg::Q_MIN;

  bit                          julia;
  logic [PIX_W-1:0]            x_off;
  logic [PIX_W-1:0]            y_off;
  logic [efp_pkg::SCALE_W-1:0] x_scale;
  logic [efp_pkg::SCALE_W-1:0] y_scale;
  longint                      c_re;
  longint                      c_im;
  logic [efp_pkg::LIMIT_W-1:0] limit;

  shade_exp_t pending_shades[$];
  int errors;
  int checked;
  int never_escaped;
  int first_step;

  function new();
    julia = 1'b0;
    x_off = efp_pkg::X_OFFSET_RST;
    y_off = efp_pkg::Y_OFFSET_RST;
    x_scale = efp_pkg::X_INV_SCALE_RST;
    y_scale = efp_pkg::Y_INV_SCALE_RST;
    c_re = efp_pkg::CONST_RE_RST;
    c_im = efp_pkg::CONST_IM_RST;
    limit = efp_pkg::ESCAPE_LIMIT_RST;
    errors = 0;
    checked = 0;
    never_escaped = 0;
    first_step = 0;
  endfunction

  function void write_reg(logic [efp_pkg::CFG_IDX_W-1:0] idx, logic [efp_pkg::QW-1:0] data);
    case (idx)
      efp_pkg::CFG_JULIA_MODE:   julia = data[0];
      efp_pkg::CFG_X_OFFSET:     x_off = data[PIX_W-1:0];
      efp_pkg::CFG_Y_OFFSET:     y_off = data[PIX_W-1:0];
      efp_pkg::CFG_X_INV_SCALE:  x_scale = data[efp_pkg::SCALE_W-1:0];
      efp_pkg::CFG_Y_INV_SCALE:  y_scale = data[efp_pkg::SCALE_W-1:0];
      efp_pkg::CFG_CONST_RE:     c_re = $signed(data);
      efp_pkg::CFG_CONST_IM:     c_im = $signed(data);
      efp_pkg::CFG_ESCAPE_LIMIT: limit = data[efp_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  function longint clamp(longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // Q16.32 product: truncate the magnitude, then apply the sign and clamp
  function longint qprod(longint a, longint b);
    logic [95:0] ma;
    logic [95:0] mb;
    logic [95:0] p;
    longint      pl;
    bit          neg;
    ma = '0;
    mb = '0;
    ma[63:0] = (a < 0) ? -a : a;
    mb[63:0] = (b < 0) ? -b : b;
    p = (ma * mb) >> 32;
    pl = p[63:0];
    neg = (a < 0) != (b < 0);
    if (neg) begin
      if (p >= 96'h8000_0000_0000) return Q_LO;
      return -pl;
    end
    if (p > 96'h7FFF_FFFF_FFFF) return Q_HI;
    return pl;
  endfunction

  function logic [efp_pkg::SHADE_W-1:0] escape_shade(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    longint re;
    longint im;
    longint cr;
    longint ci;
    longint nre;
    longint nim;
    longint s;
    int     n;
    int     steps_left;
    re = clamp((longint'(px) - longint'(x_off)) * longint'(x_scale));
    im = clamp((longint'(py) - longint'(y_off)) * longint'(y_scale));
    cr = julia ? c_re : re;
    ci = julia ? c_im : im;
    for (n = 0; n < FRACTAL_STEPS; n++) begin
      nre = clamp(clamp(qprod(re, re) - qprod(im, im)) + cr);
      nim = clamp(clamp(2 * qprod(re, im)) + ci);
      re = nre;
      im = nim;
      // exact sum, magnitude truncated to its integer part
      s = re + im;
      if (s < 0) s = -s;
      if ((s >> 32) > longint'(limit)) break;
    end
    steps_left = FRACTAL_STEPS - n;
    if (steps_left > 255) steps_left = 255;
    return steps_left[efp_pkg::SHADE_W-1:0];
  endfunction

  function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    shade_exp_t e;
    e.x = px;
    e.y = py;
    e.shade = escape_shade(px, py);
    if (e.shade == 0) never_escaped++;
    if (e.shade == 8'd255) first_step++;
    pending_shades.insert(pending_shades.size(), e);
  endfunction

  function void check_shade(logic [efp_pkg::SHADE_W-1:0] got);
    shade_exp_t e;
    if (pending_shades.size() == 0) begin
      errors++;
      if (errors <= 10) $display("error: shade %0d with no pixel outstanding", got);
      return;
    end
    e = pending_shades.pop_front();
    checked++;
    if (got !== e.shade) begin
      errors++;
      if (errors <= 10) begin
        $display("error: pixel (%0d,%0d) shade %0d, expected %0d", e.x, e.y, got, e.shade);
      end
    end
  endfunction
endclass

module escape_time_fractal_pixel_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 30000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [PIX_W-1:0]              pixel_x = '0;
  logic [PIX_W-1:0]              pixel_y = '0;
  logic                          done;
  logic [efp_pkg::SHADE_W-1:0]   shade;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [efp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [efp_pkg::QW-1:0]        cfg_data = '0;

  shade_scoreboard shade_board = new();
  view_t  cur_view;
  longint cycles = 0;
  int     idle_cycles = 0;
  int     pixels_sent = 0;
  int     reg_writes = 0;
  int     views_applied = 0;

  escape_time_fractal_pixel_unit #(
    .MAX_ITER   (FRACTAL_STEPS),
    .COORD_BITS (PIX_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .done      (done),
    .shade     (shade),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result check and watchdog
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (done !== 1'b0) shade_board.check_shade(shade);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic view_t reset_view();
    view_t v;
    v.julia = 1'b0;
    v.x_off = efp_pkg::X_OFFSET_RST;
    v.y_off = efp_pkg::Y_OFFSET_RST;
    v.x_scale = efp_pkg::X_INV_SCALE_RST;
    v.y_scale = efp_pkg::Y_INV_SCALE_RST;
    v.c_re = efp_pkg::CONST_RE_RST;
    v.c_im = efp_pkg::CONST_IM_RST;
    v.limit = efp_pkg::ESCAPE_LIMIT_RST;
    return v;
  endfunction

  // mostly within +/-4.0, sometimes anywhere in the 48-bit range
  function automatic logic [efp_pkg::QW-1:0] random_const();
    longint c;
    if ($urandom_range(0, 3) == 0) return efp_pkg::QW'({$urandom, $urandom});
    c = {$urandom_range(0, 7), $urandom};
    c = c - (64'sd1 <<< 34);
    return c[efp_pkg::QW-1:0];
  endfunction

  function automatic view_t random_view();
    view_t v;
    v.julia = 1'($urandom_range(0, 1));
    v.x_off = PIX_W'($urandom_range(0, 2047));
    v.y_off = PIX_W'($urandom_range(0, 2047));
    v.x_scale = ($urandom_range(0, 3) == 0) ? $urandom
                                             : $urandom_range(32'h0010_0000, 32'h0800_0000);
    v.y_scale = ($urandom_range(0, 3) == 0) ? $urandom
                                             : $urandom_range(32'h0010_0000, 32'h0800_0000);
    v.c_re = random_const();
    v.c_im = random_const();
    v.limit = efp_pkg::LIMIT_W'($urandom_range(0, 255));
    return v;
  endfunction

  // fill the bits above the register width with noise
  function automatic logic [efp_pkg::QW-1:0] with_junk(input logic [efp_pkg::QW-1:0] val,
                                                        input int w);
    logic [efp_pkg::QW-1:0] keep;
    logic [efp_pkg::QW-1:0] noise;
    keep = (48'd1 << w) - 48'd1;
    noise = efp_pkg::QW'({$urandom, $urandom});
    return (noise & ~keep) | (val & keep);
  endfunction

  function automatic logic [PIX_W-1:0] near(input logic [PIX_W-1:0] center, input int span);
    int v;
    v = $urandom_range(0, 2 * span);
    v = v - span + int'(center);
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return v[PIX_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] rim_coord(input logic [PIX_W-1:0] center);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return near(center, 1);
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
    start <= 1'b1;
    pixel_x <= px;
    pixel_y <= py;
    do @(posedge clk); while (busy);
    shade_board.note_pixel(px, py);
    pixels_sent++;
  endtask

  // drop start and park noise on the pixel ports
  task automatic pause(input int n);
    start <= 1'b0;
    pixel_x <= PIX_W'($urandom_range(0, 2047));
    pixel_y <= PIX_W'($urandom_range(0, 2047));
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (shade_board.pending_shades.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [efp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [efp_pkg::QW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    shade_board.write_reg(idx, data);
    reg_writes++;
  endtask

  task automatic apply_view(input view_t v);
    drain();
    write_reg(efp_pkg::CFG_JULIA_MODE, with_junk(efp_pkg::QW'(v.julia), 1));
    write_reg(efp_pkg::CFG_X_OFFSET, with_junk(efp_pkg::QW'(v.x_off), efp_pkg::OFFSET_W));
    write_reg(efp_pkg::CFG_Y_OFFSET, with_junk(efp_pkg::QW'(v.y_off), efp_pkg::OFFSET_W));
    write_reg(efp_pkg::CFG_X_INV_SCALE, with_junk(efp_pkg::QW'(v.x_scale), efp_pkg::SCALE_W));
    write_reg(efp_pkg::CFG_Y_INV_SCALE, with_junk(efp_pkg::QW'(v.y_scale), efp_pkg::SCALE_W));
    write_reg(efp_pkg::CFG_CONST_RE, v.c_re);
    write_reg(efp_pkg::CFG_CONST_IM, v.c_im);
    write_reg(efp_pkg::CFG_ESCAPE_LIMIT, with_junk(efp_pkg::QW'(v.limit), efp_pkg::LIMIT_W));
    cfg_valid <= 1'b0;
    cur_view = v;
    views_applied++;
  endtask

  // mostly uniform, some near the mapped origin, some on the range ends
  task automatic next_pixel(output logic [PIX_W-1:0] px, output logic [PIX_W-1:0] py);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) begin
      px = PIX_W'($urandom_range(0, 2047));
      py = PIX_W'($urandom_range(0, 2047));
    end else if (sel < 18) begin
      px = near(cur_view.x_off, 300);
      py = near(cur_view.y_off, 240);
    end else begin
      px = rim_coord(cur_view.x_off);
      py = rim_coord(cur_view.y_off);
    end
  endtask

  // bursts with random gaps; stop on the item count or the cycle budget
  task automatic run_random(input int count, input longint budget);
    int               sent;
    int               burst;
    int               gap;
    longint           t0;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    sent = 0;
    t0 = cycles;
    while (sent < count && cycles - t0 < budget) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && sent < count) begin
        next_pixel(px, py);
        send_pixel(px, py);
        sent++;
        burst--;
      end
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 4);
        2:       gap = $urandom_range(5, 40);
        default: gap = $urandom_range(41, 120);
      endcase
      if (gap > 0) pause(gap);
    end
  endtask

  initial begin
    view_t v;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    cur_view = reset_view();
    views_applied = 1;
    @(posedge clk);

    // reset view: corners, alternating bit patterns, known interior points
    send_pixel(11'd0, 11'd0);
    send_pixel(11'd2047, 11'd2047);
    send_pixel(11'd0, 11'd2047);
    send_pixel(11'd2047, 11'd0);
    send_pixel(11'h555, 11'h2AA);
    send_pixel(11'h2AA, 11'h555);
    send_pixel(11'd1, 11'd1);
    send_pixel(11'd1024, 11'd1024);
    send_pixel(11'd2047, 11'd302);
    send_pixel(11'd520, 11'd0);
    send_pixel(11'd520, 11'd302);
    send_pixel(11'd230, 11'd302);
    send_pixel(11'd520, 11'd503);
    pause(3);
    run_random(500, 4000000);

    v = reset_view();
    v.julia = 1'b1;
    apply_view(v);
    run_random(350, 2800000);

    // zero scales put every pixel at the origin: nothing escapes
    v = '0;
    apply_view(v);
    send_pixel(11'd0, 11'd0);
    send_pixel(11'd2047, 11'd2047);
    send_pixel(11'h555, 11'h2AA);
    v.julia = 1'b1;
    v.x_off = '1;
    v.y_off = '1;
    v.limit = '1;
    apply_view(v);
    send_pixel(11'd0, 11'd0);
    send_pixel(11'd2047, 11'd2047);

    // full-scale mapping with saturating Julia constants
    v.julia = 1'b1;
    v.x_off = '1;
    v.y_off = '0;
    v.x_scale = '1;
    v.y_scale = '1;
    v.c_re = efp_pkg::Q_MAX;
    v.c_im = efp_pkg::Q_MIN;
    v.limit = '1;
    apply_view(v);
    send_pixel(11'd2047, 11'd0);
    send_pixel(11'd0, 11'd2047);
    send_pixel(11'd0, 11'd0);
    run_random(60, 480000);

    v.julia = 1'b0;
    v.x_off = '0;
    v.y_off = '1;
    v.c_re = efp_pkg::Q_MIN;
    v.c_im = efp_pkg::Q_MAX;
    v.limit = '0;
    apply_view(v);
    run_random(150, 1200000);

    // zoomed out around the middle of the pixel range, tightest escape test
    v = reset_view();
    v.x_off = 11'd1024;
    v.y_off = 11'd1024;
    v.x_scale = 32'h0400_0000;
    v.y_scale = 32'h0400_0000;
    v.limit = '0;
    apply_view(v);
    run_random(250, 2000000);

    repeat (6) begin
      apply_view(random_view());
      run_random(100, 800000);
    end

    drain();
    repeat (50) @(posedge clk);

    $display("summary: %0d pixels across %0d views, %0d register writes, %0d cycles",
             pixels_sent, views_applied, reg_writes, cycles);
    $display("summary: %0d shades checked, %0d never escaped, %0d escaped on step one, %0d errors",
             shade_board.checked, shade_board.never_escaped, shade_board.first_step,
             shade_board.errors);
    if (shade_board.errors == 0 && shade_board.pending_shades.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/efp_pkg.sv
rtl/efp_mul.sv
rtl/escape_time_fractal_pixel_unit.sv
test/escape_time_fractal_pixel_unit_tb.sv
